// ===== src/ugb_pkg.sv =====
// ----------------------------------------------------------------------------
// ugb_pkg
// Shared constants and types of the undirected graph search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ugb_pkg;

  localparam int NumVert = 64;
  localparam int VidW    = 6;
  localparam int DistW   = 7;

  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncSearch = 2'd2;
  localparam logic [1:0] FuncRsvd   = 2'd3;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusNoPath  = 2'd2;

  localparam logic [DistW-1:0] DistNone = 7'h7f;

  // Per-vertex search record: distance, next hop and its valid flag.
  typedef struct packed {
    logic [DistW-1:0] level;
    logic [VidW-1:0]  hop;
    logic             hop_ok;
  } vrec_t;

endpackage

// ===== src/ugb_adj_ram.sv =====
// ----------------------------------------------------------------------------
// ugb_adj_ram
// Adjacency matrix with one row per vertex, one read port and one write
// port, plus a per-row written flag kept in flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugb_adj_ram import ugb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [VidW-1:0]     ra_addr_i,
  output logic [NumVert-1:0]  ra_data_o,
  input  logic                we_i,
  input  logic [VidW-1:0]     wa_addr_i,
  input  logic [NumVert-1:0]  wa_data_i,
  output logic [NumVert-1:0]  row_used_o
);

  logic [NumVert-1:0] mem [NumVert];
  logic [NumVert-1:0] used_q;

  // Rows read as zero until first written, tracked by a valid bit per row.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_addr_i] <= wa_data_i;
    end
    ra_data_o <= used_q[ra_addr_i] ? mem[ra_addr_i] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (we_i) begin
      used_q[wa_addr_i] <= 1'b1;
    end
  end

  assign row_used_o = used_q;

endmodule

// ===== src/ugb_vrec_ram.sv =====
// ----------------------------------------------------------------------------
// ugb_vrec_ram
// Per-vertex search record store, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugb_vrec_ram import ugb_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [VidW-1:0] waddr_i,
  input  vrec_t           wdata_i,
  input  logic [VidW-1:0] raddr_i,
  output vrec_t           rdata_o
);

  vrec_t mem [NumVert];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/undirected_graph_bfs_engine.sv =====
// ----------------------------------------------------------------------------
// undirected_graph_bfs_engine
// Adjacency-matrix graph store with edge add, edge query and BFS search.
// Add updates both adjacency rows (SAddA to SAddC), loads its result, then
// passes SOut. Query, or a search with an endpoint without edges, loads its
// result directly. Search: a check, a clear of every record, then per popped
// vertex SPopW, SPop, SLd and SScan steps, one per newly reached neighbor, a
// target read, then SEmitR and SEmitW per result row. Output stalls hold it.
// Reset clears the graph (row valid bits) and all control; no sweep needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module undirected_graph_bfs_engine import ugb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic [VidW-1:0]         first_vertex_i,
  input  logic [VidW-1:0]         second_vertex_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic                    edge_present_o,
  output logic signed [DistW-1:0] target_distance_o,
  output logic [VidW-1:0]         vertex_id_o,
  output logic signed [DistW-1:0] vertex_distance_o,
  output logic [VidW-1:0]         next_hop_o,
  output logic                    hop_valid_o,
  output logic                    last_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SAddA  = 4'd1;
  localparam logic [3:0] SAddB  = 4'd2;
  localparam logic [3:0] SAddC  = 4'd3;
  localparam logic [3:0] SQry   = 4'd4;
  localparam logic [3:0] SChk   = 4'd5;
  localparam logic [3:0] SClr   = 4'd6;
  localparam logic [3:0] SPop   = 4'd7;
  localparam logic [3:0] SPopW  = 4'd8;
  localparam logic [3:0] SScan  = 4'd9;
  localparam logic [3:0] STgt   = 4'd10;
  localparam logic [3:0] SEmitR = 4'd11;
  localparam logic [3:0] SEmitW = 4'd12;
  localparam logic [3:0] SOut   = 4'd13;
  localparam logic [3:0] SLd    = 4'd14;

  logic [3:0] state_q;

  logic [VidW-1:0] a_q, b_q;
  logic [VidW-1:0] cnt_q;
  logic            cnt_end_q;
  logic [VidW:0]   head_q, tail_q;
  logic [VidW-1:0] cur_q;
  logic [DistW-1:0] cur_dist_q;
  logic [NumVert-1:0] pend_q;
  logic [NumVert-1:0] seen_q;
  logic [DistW-1:0] tdist_q;
  logic [VidW-1:0] emit_q;
  logic [VidW-1:0] queue_mem [NumVert];
  logic [VidW-1:0] queue_rd_q;
  logic [DistW-1:0] cur_dist_l;
  logic [DistW-1:0] qdist_mem [NumVert];

  // Output register.
  logic            ov_q;
  logic            out_load;
  logic [1:0]      st_q;
  logic            ep_q;
  logic [DistW-1:0] td_q, vd_q;
  logic [VidW-1:0] vid_q, nh_q;
  logic            hv_q, last_q;

  // Adjacency memory.
  logic [VidW-1:0]    adj_ra;
  logic [NumVert-1:0] adj_rd;
  logic               adj_we;
  logic [VidW-1:0]    adj_wa;
  logic [NumVert-1:0] adj_wd;
  logic [NumVert-1:0] row_used;

  ugb_adj_ram u_adj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ra_addr_i  (adj_ra),
    .ra_data_o  (adj_rd),
    .we_i       (adj_we),
    .wa_addr_i  (adj_wa),
    .wa_data_i  (adj_wd),
    .row_used_o (row_used)
  );

  // Vertex record memory.
  logic            vr_we;
  logic [VidW-1:0] vr_wa, vr_ra;
  vrec_t           vr_wd, vr_rd;

  ugb_vrec_ram u_vrec (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (vr_wa),
    .wdata_i (vr_wd),
    .raddr_i (vr_ra),
    .rdata_o (vr_rd)
  );

  logic in_fire, out_free;
  logic [VidW-1:0] pend_idx;
  logic            pend_any;
  logic [NumVert-1:0] pend_lowbit;

  assign in_stall_o = (state_q != SIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // Lowest pending neighbor: isolate lowest set bit, then encode it.
  assign pend_lowbit = pend_q & (~pend_q + NumVert'(1));
  assign pend_any    = |pend_q;
  always_comb begin
    pend_idx = '0;
    for (int i = 0; i < NumVert; i++) begin
      if (pend_lowbit[i]) begin
        pend_idx = VidW'(i);
      end
    end
  end

  // Next used row at or above the emit counter.
  logic [NumVert-1:0] used_from;
  logic [NumVert-1:0] used_low;
  logic [VidW-1:0]    used_idx;
  logic               used_any;
  assign used_from = row_used & ~((NumVert'(1) << cnt_q) - NumVert'(1));
  assign used_low  = used_from & (~used_from + NumVert'(1));
  assign used_any  = |used_from;
  always_comb begin
    used_idx = '0;
    for (int i = 0; i < NumVert; i++) begin
      if (used_low[i]) begin
        used_idx = VidW'(i);
      end
    end
  end

  logic [NumVert-1:0] used_after;
  assign used_after = row_used & ~((NumVert'(2) << emit_q) - NumVert'(1));

  // Control and datapath.
  always_comb begin
    adj_ra   = a_q;
    adj_we   = 1'b0;
    adj_wa   = a_q;
    adj_wd   = adj_rd;
    vr_we    = 1'b0;
    vr_wa    = cnt_q;
    vr_wd    = '{level: DistNone, hop: '0, hop_ok: 1'b0};
    vr_ra    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      SIdle: begin
        adj_ra = first_vertex_i;
      end
      SAddA: begin
        adj_ra = b_q;
        adj_we = 1'b1;
        adj_wa = a_q;
        adj_wd = adj_rd | (NumVert'(1) << b_q);
      end
      SAddB: begin
        adj_ra = b_q;
      end
      SAddC: begin
        adj_ra   = b_q;
        adj_we   = 1'b1;
        adj_wa   = b_q;
        adj_wd   = adj_rd | (NumVert'(1) << a_q);
        out_load = out_free;
      end
      SQry: begin
        out_load = out_free;
      end
      SChk: begin
        out_load = out_free && (!row_used[a_q] || !row_used[b_q]);
      end
      SClr: begin
        vr_we = 1'b1;
        vr_wa = cnt_q;
        if (cnt_q == a_q) begin
          vr_wd = '{level: '0, hop: a_q, hop_ok: 1'b1};
        end
      end
      SPop: begin
        adj_ra = queue_rd_q;
      end
      SScan: begin
        if (pend_any) begin
          vr_we = 1'b1;
          vr_wa = pend_idx;
          vr_wd = '{level: cur_dist_q + DistW'(1), hop: cur_q, hop_ok: 1'b1};
        end
      end
      STgt: begin
        vr_ra = b_q;
      end
      SEmitR: begin
        vr_ra = used_idx;
      end
      SEmitW: begin
        vr_ra    = emit_q;
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SScan && pend_any) begin
      queue_mem[tail_q[VidW-1:0]] <= pend_idx;
    end else if (state_q == SClr && cnt_q == a_q) begin
      queue_mem['0] <= a_q;
    end
    queue_rd_q <= queue_mem[head_q[VidW-1:0]];
  end

  // Output valid: set when a result loads, cleared once it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      cnt_end_q <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_fire) begin
            a_q    <= first_vertex_i;
            b_q    <= second_vertex_i;
            case (func_i)
              FuncAdd:    state_q <= SAddA;
              FuncQuery:  state_q <= SQry;
              FuncSearch: state_q <= SChk;
              default:    state_q <= SIdle;
            endcase
          end
        end
        SAddA: state_q <= SAddB;
        SAddB: state_q <= SAddC;
        SAddC, SQry: begin
          if (out_free) begin
            st_q   <= StatusOk;
            ep_q   <= (state_q == SQry) ? adj_rd[b_q] : 1'b0;
            td_q   <= '0;
            vid_q  <= '0;
            vd_q   <= '0;
            nh_q   <= '0;
            hv_q   <= 1'b0;
            last_q <= 1'b1;
            state_q <= (state_q == SQry) ? SIdle : SOut;
          end
        end
        SOut: state_q <= SIdle;
        SChk: begin
          if (!row_used[a_q] || !row_used[b_q]) begin
            if (out_free) begin
              st_q   <= StatusInvalid;
              ep_q   <= 1'b0;
              td_q   <= DistNone;
              vid_q  <= '0;
              vd_q   <= '0;
              nh_q   <= '0;
              hv_q   <= 1'b0;
              last_q <= 1'b1;
              state_q <= SIdle;
            end
          end else begin
            cnt_q   <= '0;
            seen_q  <= '0;
            state_q <= SClr;
          end
        end
        SClr: begin
          cnt_q <= cnt_q + VidW'(1);
          if (cnt_q == a_q) begin
            seen_q[a_q] <= 1'b1;
          end
          if (cnt_q == VidW'(NumVert - 1)) begin
            head_q  <= '0;
            tail_q  <= (VidW+1)'(1);
            state_q <= (a_q == b_q) ? STgt : SPopW;
          end
        end
        SPopW: begin
          // Queue read address settles; data registered next cycle.
          state_q <= SPop;
        end
        SPop: begin
          cur_q   <= queue_rd_q;
          head_q  <= head_q + (VidW+1)'(1);
          state_q <= SLd;
        end
        SLd: begin
          // Adjacency row of the popped vertex arrives this cycle.
          state_q <= SScan;
        end
        SScan: begin
          if (pend_any) begin
            seen_q[pend_idx] <= 1'b1;
            tail_q <= tail_q + (VidW+1)'(1);
          end else if (cur_q == b_q || head_q == tail_q) begin
            state_q <= STgt;
          end else begin
            state_q <= SPopW;
          end
        end
        STgt: begin
          cnt_q   <= '0;
          state_q <= SEmitR;
        end
        SEmitR: begin
          if (state_q == SEmitR && cnt_q == '0 && !cnt_end_q) begin
            tdist_q <= vr_rd.level;
          end
          emit_q  <= used_idx;
          state_q <= SEmitW;
        end
        SEmitW: begin
          if (out_free) begin
            st_q   <= (tdist_q == DistNone) ? StatusNoPath : StatusOk;
            ep_q   <= 1'b0;
            td_q   <= tdist_q;
            vid_q  <= emit_q;
            vd_q   <= vr_rd.level;
            nh_q   <= vr_rd.hop_ok ? vr_rd.hop : '0;
            hv_q   <= vr_rd.hop_ok;
            last_q <= !(|used_after);
            if (|used_after) begin
              cnt_q     <= emit_q + VidW'(1);
              cnt_end_q <= 1'b1;
              state_q   <= SEmitR;
            end else begin
              cnt_end_q <= 1'b0;
              state_q   <= SIdle;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Pending-neighbor mask and distance of the popped vertex.
  always_ff @(posedge clk_i) begin
    if (state_q == SLd) begin
      pend_q <= adj_rd & ~seen_q;
    end else if (state_q == SScan && pend_any) begin
      pend_q[pend_idx] <= 1'b0;
    end
    if (state_q == SPop) begin
      cur_dist_q <= cur_dist_l;
    end
  end

  // Distance of the popped vertex comes from a distance queue; read at pop time.
  always_ff @(posedge clk_i) begin
    if (state_q == SScan && pend_any) begin
      qdist_mem[tail_q[VidW-1:0]] <= cur_dist_q + DistW'(1);
    end else if (state_q == SClr && cnt_q == a_q) begin
      qdist_mem['0] <= '0;
    end
    cur_dist_l <= qdist_mem[head_q[VidW-1:0]];
  end

  assign out_valid_o       = ov_q;
  assign status_o          = st_q;
  assign edge_present_o    = ep_q;
  assign target_distance_o = td_q;
  assign vertex_id_o       = vid_q;
  assign vertex_distance_o = vd_q;
  assign next_hop_o        = nh_q;
  assign hop_valid_o       = hv_q;
  assign last_o            = last_q;

  // The engine never accepts an item while a search is under way.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> in_stall_o)
    else $error("item accepted during search");

  // Queue tail never runs behind its head.
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (tail_q >= head_q))
    else $error("queue head passed tail");

  // A held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(vid_q) && $stable(last_q)))
    else $error("stalled result changed");

endmodule

// ===== dv/tb_undirected_graph_bfs_engine.sv =====
// ----------------------------------------------------------------------------
// tb_undirected_graph_bfs_engine
// Self-checking bench for the graph engine: edge add, edge query and BFS.
// A predictor keeps its own adjacency matrix, updates or searches it for
// every accepted item and queues the expected result rows for comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_undirected_graph_bfs_engine;
  import ugb_pkg::*;

  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic [1:0]       status;
    logic             edge_present;
    logic [DistW-1:0] target_distance;
    logic [VidW-1:0]  vertex_id;
    logic [DistW-1:0] vertex_distance;
    logic [VidW-1:0]  next_hop;
    logic             hop_valid;
    logic             last;
  } row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              func_i;
  logic [VidW-1:0]         first_vertex_i;
  logic [VidW-1:0]         second_vertex_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [1:0]              status_o;
  logic                    edge_present_o;
  logic signed [DistW-1:0] target_distance_o;
  logic [VidW-1:0]         vertex_id_o;
  logic signed [DistW-1:0] vertex_distance_o;
  logic [VidW-1:0]         next_hop_o;
  logic                    hop_valid_o;
  logic                    last_o;

  undirected_graph_bfs_engine dut (.*);

  // Predictor state and expected rows.
  logic [NumVert-1:0] graph_adj [NumVert];
  row_t               pending_rows [$];
  int                 n_errors;
  int                 n_items;
  int                 n_rows;
  int                 n_searches;
  int                 idle_pct;
  int                 stall_pct;
  bit                 hold_off;
  int                 quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Expected rows for one accepted item.
  function automatic void predict_graph_op(logic [1:0] fn, logic [VidW-1:0] a,
                                           logic [VidW-1:0] b);
    row_t             r;
    logic [DistW-1:0] level [NumVert];
    logic [VidW-1:0]  hop [NumVert];
    logic             known [NumVert];
    logic [VidW-1:0]  fifo [$];
    logic [VidW-1:0]  cur;
    row_t             rows [$];
    r = '0;
    r.last = 1'b1;
    if (fn == FuncAdd) begin
      graph_adj[a][b] = 1'b1;
      graph_adj[b][a] = 1'b1;
      pending_rows.push_back(r);
    end else if (fn == FuncQuery) begin
      r.edge_present = graph_adj[a][b];
      pending_rows.push_back(r);
    end else if (fn == FuncSearch) begin
      n_searches++;
      if (graph_adj[a] == '0 || graph_adj[b] == '0) begin
        r.status = StatusInvalid;
        r.target_distance = DistNone;
        pending_rows.push_back(r);
        return;
      end
      for (int v = 0; v < NumVert; v++) begin
        level[v] = DistNone;
        hop[v] = '0;
        known[v] = 1'b0;
      end
      level[a] = '0;
      hop[a] = a;
      known[a] = 1'b1;
      fifo.push_back(a);
      cur = a;
      while (fifo.size() > 0 && cur != b) begin
        cur = fifo.pop_front();
        for (int n = 0; n < NumVert; n++) begin
          if (graph_adj[cur][n] && level[n] == DistNone) begin
            level[n] = level[cur] + DistW'(1);
            hop[n] = cur;
            known[n] = 1'b1;
            fifo.push_back(VidW'(n));
          end
        end
      end
      for (int v = 0; v < NumVert; v++) begin
        if (graph_adj[v] == '0) continue;
        r = '0;
        r.status = (level[b] == DistNone) ? StatusNoPath : StatusOk;
        r.target_distance = level[b];
        r.vertex_id = VidW'(v);
        r.vertex_distance = level[v];
        r.next_hop = known[v] ? hop[v] : '0;
        r.hop_valid = known[v];
        rows.push_back(r);
      end
      rows[rows.size()-1].last = 1'b1;
      foreach (rows[i]) pending_rows.push_back(rows[i]);
    end
  endfunction

  // Receiver: random stall, optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted row with the oldest expectation.
  always @(posedge clk_i) begin
    row_t got;
    row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, edge_present_o, target_distance_o, vertex_id_o,
              vertex_distance_o, next_hop_o, hop_valid_o, last_o};
      n_rows++;
      if (pending_rows.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected row, actual %h", $time, got);
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          n_errors++;
          $display("%0t: row mismatch, expected %h actual %h", $time, want, got);
          $display("  st %0d/%0d ep %0d/%0d td %0d/%0d vid %0d/%0d vd %0d/%0d",
                   want.status, got.status, want.edge_present, got.edge_present,
                   $signed(want.target_distance), $signed(got.target_distance),
                   want.vertex_id, got.vertex_id, $signed(want.vertex_distance),
                   $signed(got.vertex_distance));
          $display("  nh %0d/%0d hv %0d/%0d last %0d/%0d", want.next_hop,
                   got.next_hop, want.hop_valid, got.hop_valid, want.last, got.last);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; valid drops only when idling.
  task automatic send_item(logic [1:0] fn, logic [VidW-1:0] a, logic [VidW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    first_vertex_i <= a;
    second_vertex_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (fn != FuncRsvd) predict_graph_op(fn, a, b);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Extremes, every operation, and the named corner cases.
  task automatic test_directed();
    send_item(FuncSearch, 6'd0, 6'd63);      // endpoints without edges
    send_item(FuncQuery, 6'd0, 6'd63);
    send_item(FuncAdd, 6'd0, 6'd63);
    send_item(FuncAdd, 6'd5, 6'd5);          // self-loop
    send_item(FuncQuery, 6'd63, 6'd0);
    send_item(FuncQuery, 6'd5, 6'd5);
    send_item(FuncRsvd, 6'd1, 6'd2);         // unused code, ignored
    send_item(FuncSearch, 6'd0, 6'd63);
    send_item(FuncSearch, 6'd63, 6'd63);     // source equals target
    send_item(FuncSearch, 6'd0, 6'd5);       // target not reachable
    send_item(FuncSearch, 6'd0, 6'd1);       // target has no edges
    send_item(FuncAdd, 6'd63, 6'd42);
    send_item(FuncAdd, 6'd42, 6'd21);
    send_item(FuncAdd, 6'd21, 6'd0);
    send_item(FuncSearch, 6'd0, 6'd42);
    send_item(FuncSearch, 6'd5, 6'd5);
    send_item(FuncQuery, 6'd42, 6'd21);
    wait_drained();
  endtask

  // Random mix in one idling phase: mostly adds and searches.
  task automatic test_random(int count, int idle, int stall);
    int k;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        send_item(FuncAdd, VidW'($urandom_range(63)), VidW'($urandom_range(63)));
      end else if (k < 65) begin
        send_item(FuncQuery, VidW'($urandom_range(63)), VidW'($urandom_range(63)));
      end else if (k < 97) begin
        send_item(FuncSearch, VidW'($urandom_range(63)), VidW'($urandom_range(63)));
      end else begin
        send_item(FuncRsvd, VidW'($urandom), VidW'($urandom));
      end
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering queries.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_item(FuncQuery, VidW'($urandom_range(63)), VidW'($urandom_range(63)));
    join
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = '0;
    first_vertex_i = '0;
    second_vertex_i = '0;
    out_stall_i = 1'b0;
    hold_off = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    n_errors = 0;
    n_items = 0;
    n_rows = 0;
    n_searches = 0;
    quiet_cycles = 0;
    for (int v = 0; v < NumVert; v++) graph_adj[v] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 82, 0);
    test_random(100, 0, 82);
    test_random(100, 36, 36);
    test_backpressure();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d items (%0d searches) and %0d result rows", n_items,
             n_searches, n_rows);
    $display("over four idling phases and one long receiver hold-off.");
    if (n_errors == 0 && pending_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
